// File: design/positional_list_store_defines.svh
// Assertion macros shared by the positional list store RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// The condition must hold in every cycle outside reset.
`define PLS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define PLS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/pls_pkg.sv
// Shared types and constants of the positional list store.
// Used by the cell, the read tree and the top level; depends on nothing.
`default_nettype none

package pls_pkg;

	// Port widths of the command and result words.
	localparam int KIND_W   = 3;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Operation codes.
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// Read tree group size.
	localparam int GRP = 8;

	// Broadcast to every cell: which update the accepted word performs.
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
		logic rd;
	} cell_op_t;

endpackage

`default_nettype wire

// File: design/positional_list_store.sv
// Positional list store, top level: control, entry count, chain of cells and read path.
// Depends on pls_pkg, pls_cell, pls_rd_tree and positional_list_store_defines.svh.
//
// Every command word (insert, remove, read, write, clear at a zero-based position) is taken
// in the cycle start is high; busy never rises, so one word can be taken in every cycle.
// The list lives in a row of CAPACITY cells, and each cell shifts toward its neighbor,
// loads the new value or holds, all in the same clock edge, so the list and its count are
// up to date for the very next word. The result word appears with done after the
// registered group stage of the read tree and its output register, and results come back
// in command order. The receiver cannot stall the block: done lasts one cycle and the
// result must be captured then. read_data is zero for anything but a successful read,
// status tells ok, bad position or full list, and entry_count and is_empty give the list
// after the operation.
`default_nettype none

`include "positional_list_store_defines.svh"

module positional_list_store #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [pls_pkg::KIND_W-1:0]     kind,
	input  wire logic [pls_pkg::POS_W-1:0]      position,
	input  wire logic [pls_pkg::WORD_W-1:0]     value,
	output logic                                done,
	output logic      [pls_pkg::WORD_W-1:0]     read_data,
	output logic      [pls_pkg::STATUS_W-1:0]   status,
	output logic      [pls_pkg::COUNT_W-1:0]    entry_count,
	output logic                                is_empty
);
	import pls_pkg::*;

	// Count width holds CAPACITY itself; compares run at the wider of count and position.
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          accept;

	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] cap_x;

	cell_op_t          op_dec;
	cell_op_t          op;
	logic [STATUS_W-1:0] st_dec;

	logic [CW-1:0]         cell_pos;
	logic [DATA_WIDTH-1:0] cell_val;
	logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_lane [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_q;

	// Result pipeline: stage one waits for the read tree, then the output register.
	logic                vld_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [COUNT_W-1:0]  cnt_s1;
	logic                empty_s1;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic                empty_q;

	// The list updates in the same edge that takes the word, so the block never holds a word off.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign pos_x = CMPW'(position);
	assign cnt_x = CMPW'(count_q);
	assign cap_x = CMPW'(CAPACITY);

	// Decode the word against the current count. An insert checks its position before
	// it checks for a full list; an unused code reports a bad position and changes nothing.
	always_comb begin
		op_dec  = '0;
		st_dec  = ST_OK;
		count_d = count_q;
		unique case (kind)
			KIND_INSERT: begin
				if (pos_x > cnt_x) begin
					st_dec = ST_BAD_POS;
				end else if (cnt_x >= cap_x) begin
					st_dec = ST_FULL;
				end else begin
					op_dec.ins = 1'b1;
					count_d    = count_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (pos_x >= cnt_x) begin
					st_dec = ST_BAD_POS;
				end else begin
					op_dec.rem = 1'b1;
					count_d    = count_q - CW'(1);
				end
			end
			KIND_READ: begin
				if (pos_x >= cnt_x) begin
					st_dec = ST_BAD_POS;
				end else begin
					op_dec.rd = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (pos_x >= cnt_x) begin
					st_dec = ST_BAD_POS;
				end else begin
					op_dec.wr = 1'b1;
				end
			end
			KIND_CLEAR: begin
				count_d = '0;
			end
			default: begin
				st_dec = ST_BAD_POS;
			end
		endcase
	end

	assign op = accept ? op_dec : '0;

	// Cells only act on a valid position, which always fits in the count width.
	assign cell_pos = CW'(position);
	assign cell_val = DATA_WIDTH'(value);

	// The chain: cell i sees cell i-1 on its left and cell i+1 on its right. The end
	// cells see themselves where they have no neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = cell_q[i];
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_q[i];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		pls_cell #(
			.CAPACITY   (CAPACITY),
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.pos     (cell_pos),
			.value   (cell_val),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_q[i]),
			.rd_lane (rd_lane[i])
		);
	end

	// A read only ever selects one cell, so the read bus is a plain OR of the lanes.
	pls_rd_tree #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_rd_tree (
		.clk   (clk),
		.lanes (rd_lane),
		.rd_q  (rd_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			vld_s1 <= accept;
			done_q <= vld_s1;
		end
	end

	// Result payload registers follow the valid bits above and need no reset.
	always_ff @(posedge clk) begin
		status_s1 <= st_dec;
		cnt_s1    <= COUNT_W'(count_d);
		empty_s1  <= (count_d == '0);
		status_q  <= status_s1;
		cnt_q     <= cnt_s1;
		empty_q   <= empty_s1;
	end

	assign done        = done_q;
	assign read_data   = WORD_W'(rd_q);
	assign status      = status_q;
	assign entry_count = cnt_q;
	assign is_empty    = empty_q;

	`PLS_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count exceeds capacity")
	`PLS_ASSERT_NEXT(a_accept_s1, accept, vld_s1, "accepted word lost before stage one")
	`PLS_ASSERT_NEXT(a_s1_done, vld_s1, done, "stage one word did not reach the output")
	`PLS_ASSERT_IMPLY(a_empty_flag, done, is_empty == (entry_count == '0), "empty flag mismatch")

endmodule

`default_nettype wire

// File: design/pls_cell.sv
// One list entry: holds, takes its left or right neighbor, or loads the new value.
// Depends on pls_pkg for the cell operation struct.
`default_nettype none

module pls_cell #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  wire logic                           clk,
	input  wire pls_pkg::cell_op_t              op,
	input  wire logic [$clog2(CAPACITY+1)-1:0]  pos,
	input  wire logic [DATA_WIDTH-1:0]          value,
	input  wire logic [DATA_WIDTH-1:0]          left,
	input  wire logic [DATA_WIDTH-1:0]          right,
	output logic      [DATA_WIDTH-1:0]          data,
	output logic      [DATA_WIDTH-1:0]          rd_lane
);
	import pls_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;
	logic                  hit;

	assign hit = (pos == IDX);

	always_comb begin
		data_d = data_q;
		priority if (op.ins) begin
			if (pos < IDX) begin
				data_d = left;
			end else if (hit) begin
				data_d = value;
			end
		end else if (op.rem) begin
			if (pos <= IDX) begin
				data_d = right;
			end
		end else if (op.wr) begin
			if (hit) begin
				data_d = value;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	assign rd_lane = (op.rd && hit) ? data_q : '0;

endmodule

`default_nettype wire

// File: design/pls_rd_tree.sv
// Two-level registered OR tree that collects the one selected cell onto the read bus.
// Depends on pls_pkg for the group size.
`default_nettype none

module pls_rd_tree #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic [DATA_WIDTH-1:0] lanes [CAPACITY],
	output logic      [DATA_WIDTH-1:0] rd_q
);
	import pls_pkg::*;

	localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

	logic [DATA_WIDTH-1:0] pad   [NGRP*GRP];
	logic [DATA_WIDTH-1:0] grp_d [NGRP];
	logic [DATA_WIDTH-1:0] grp_s1 [NGRP];
	logic [DATA_WIDTH-1:0] rd_d;

	for (genvar i = 0; i < NGRP * GRP; i++) begin : g_pad
		if (i < CAPACITY) begin : g_lane
			assign pad[i] = lanes[i];
		end else begin : g_zero
			assign pad[i] = '0;
		end
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				grp_d[g] = grp_d[g] | pad[g*GRP + k];
			end
		end
	end

	always_comb begin
		rd_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_d = rd_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
		rd_q   <= rd_d;
	end

endmodule

`default_nettype wire
